>>> hw/rtl/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/fwas_pkg.sv
// Types, constants and codes for the front wall align and square controller.
`default_nettype none
package fwas_pkg;

  localparam int RANGE_BITS = 13;
  localparam int GAIN_W     = 12;

  localparam logic [31:0] INVALID_MM = 32'd8190;
  localparam logic [31:0] STABLE_MS  = 32'd120;
  localparam logic [31:0] TIMEOUT_MS = 32'd2200;
  localparam logic [4:0]  TURN_LIMIT = 5'd28;
  localparam logic [7:0]  TARGET_HI  = 8'd140;
  localparam logic [7:0]  TARGET_LO  = 8'd20;
  localparam logic [6:0]  PWM_FULL   = 7'd100;

  typedef enum logic [1:0] {
    ST_RUNNING    = 2'd0,
    ST_ALIGNED    = 2'd1,
    ST_NO_READING = 2'd2,
    ST_TIMEOUT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_TARGET      = 3'd0,
    CFG_MAX_PWM     = 3'd1,
    CFG_MIN_PWM     = 3'd2,
    CFG_DIST_TOL    = 3'd3,
    CFG_SQUARE_TOL  = 3'd4,
    CFG_DIST_GAIN   = 3'd5,
    CFG_SQUARE_GAIN = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]        target_mm;
    logic [6:0]        max_pwm;
    logic [6:0]        min_pwm;
    logic [7:0]        dist_tol_mm;
    logic [7:0]        square_tol_mm;
    logic [GAIN_W-1:0] dist_gain;
    logic [GAIN_W-1:0] square_gain;
  } cfg_t;

  typedef struct packed {
    logic              lv;
    logic              rv;
    logic              dist_ok;
    logic              square_ok;
    logic signed [7:0] left;
    logic signed [7:0] right;
  } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/fwas_cmd.sv
// Wheel command datapath: error terms, proportional gains, clamp and dead-zone lift.
`default_nettype none
module fwas_cmd (
  input  logic [fwas_pkg::RANGE_BITS-1:0] left_mm,
  input  logic                            left_flag,
  input  logic [fwas_pkg::RANGE_BITS-1:0] right_mm,
  input  logic                            right_flag,
  input  fwas_pkg::cfg_t                  cfg,
  output fwas_pkg::cmd_t                  res
);
  import fwas_pkg::*;

  localparam int ERR_W = RANGE_BITS + 2;
  localparam int MAG_W = RANGE_BITS + 1;
  localparam int DP_W  = GAIN_W + MAG_W + 1;
  localparam int SP_W  = GAIN_W + RANGE_BITS + 1;

  logic                    lv, rv, both;
  logic [7:0]              tgt;
  logic [6:0]              minf, maxf;
  logic [RANGE_BITS-1:0]   single;
  logic [RANGE_BITS:0]     sum;
  logic signed [ERR_W-1:0] err2;
  logic [MAG_W-1:0]        aerr2;
  logic signed [RANGE_BITS:0] sq;
  logic [RANGE_BITS-1:0]   asq;
  logic                    dist_ok, square_ok;
  logic [DP_W-1:0]         dprod;
  logic [DP_W-10:0]        dmag_raw;
  logic [6:0]              dmag;
  logic [SP_W-1:0]         sprod;
  logic [SP_W-9:0]         tm_raw;
  logic [4:0]              tm_sat;
  logic [6:0]              tmag;
  logic signed [7:0]       drive, turn;
  logic signed [8:0]       lsum, rsum;

  function automatic logic signed [7:0] clamp_lift(input logic signed [8:0] v,
                                                   input logic [6:0] lim,
                                                   input logic [6:0] flr);
    logic signed [8:0] hi, lo, f, c;
    hi = $signed({2'b00, lim});
    lo = -hi;
    f  = $signed({2'b00, flr});
    if (v < lo) begin
      c = lo;
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    if (c > 0 && c < f) begin
      c = f;
    end else if (c < 0 && c > -f) begin
      c = -f;
    end
    return c[7:0];
  endfunction

  assign lv   = left_flag && (32'(left_mm) < INVALID_MM);
  assign rv   = right_flag && (32'(right_mm) < INVALID_MM);
  assign both = lv && rv;

  always_comb begin
    if (cfg.target_mm < TARGET_LO) begin
      tgt = TARGET_LO;
    end else if (cfg.target_mm > TARGET_HI) begin
      tgt = TARGET_HI;
    end else begin
      tgt = cfg.target_mm;
    end
    minf = (cfg.min_pwm > PWM_FULL) ? PWM_FULL : cfg.min_pwm;
    if (cfg.max_pwm < minf) begin
      maxf = minf;
    end else if (cfg.max_pwm > PWM_FULL) begin
      maxf = PWM_FULL;
    end else begin
      maxf = cfg.max_pwm;
    end
  end

  assign single = lv ? left_mm : right_mm;
  assign sum    = both ? ({1'b0, left_mm} + {1'b0, right_mm}) : {single, 1'b0};
  assign err2   = $signed({1'b0, sum}) - $signed(ERR_W'({tgt, 1'b0}));
  assign aerr2  = (err2 < 0) ? MAG_W'(-err2) : MAG_W'(err2);
  assign sq     = $signed({1'b0, left_mm}) - $signed({1'b0, right_mm});
  assign asq    = (sq < 0) ? RANGE_BITS'(-sq) : RANGE_BITS'(sq);

  assign dist_ok   = 32'(aerr2) <= 32'({cfg.dist_tol_mm, 1'b0});
  assign square_ok = !both || (32'(asq) <= 32'(cfg.square_tol_mm));

  assign dprod    = DP_W'(cfg.dist_gain) * DP_W'(aerr2) + DP_W'(256);
  assign dmag_raw = dprod[DP_W-1:9];
  assign sprod    = SP_W'(cfg.square_gain) * SP_W'(asq) + SP_W'(128);
  assign tm_raw   = sprod[SP_W-1:8];

  always_comb begin
    if (32'(dmag_raw) < 32'(minf)) begin
      dmag = minf;
    end else if (32'(dmag_raw) > 32'(maxf)) begin
      dmag = maxf;
    end else begin
      dmag = dmag_raw[6:0];
    end
    if (dist_ok) begin
      drive = '0;
    end else if (err2 > 0) begin
      drive = $signed({1'b0, dmag});
    end else begin
      drive = -$signed({1'b0, dmag});
    end

    tm_sat = (32'(tm_raw) > 32'(TURN_LIMIT)) ? TURN_LIMIT : tm_raw[4:0];
    if (drive == 0 && tm_sat != 0 && 7'(tm_sat) < minf) begin
      tmag = minf;
    end else begin
      tmag = 7'(tm_sat);
    end
    if (square_ok) begin
      turn = '0;
    end else if (sq > 0) begin
      turn = -$signed({1'b0, tmag});
    end else begin
      turn = $signed({1'b0, tmag});
    end

    lsum = $signed({drive[7], drive}) - $signed({turn[7], turn});
    rsum = $signed({drive[7], drive}) + $signed({turn[7], turn});
  end

  always_comb begin
    res.lv        = lv;
    res.rv        = rv;
    res.dist_ok   = dist_ok;
    res.square_ok = square_ok;
    res.left      = clamp_lift(lsum, maxf, minf);
    res.right     = clamp_lift(rsum, maxf, minf);
  end

endmodule
`default_nettype wire

>>> hw/rtl/front_wall_align_square.sv
// Top level of the front wall align and square controller.
// A request in the input register moves to the result register once that is free or read.
// Throughput: one request per cycle while out_ready is high; the input and result registers
// are separate, so a new request is taken while a finished result waits.
// Reset: configuration returns to defaults, the run is idle with final status running (zero),
// and both the input and result registers are empty.
`default_nettype none
module front_wall_align_square (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            start_req,
  input  logic [31:0]                     time_ms,
  input  logic [fwas_pkg::RANGE_BITS-1:0] front_left_mm,
  input  logic                            front_left_ok,
  input  logic [fwas_pkg::RANGE_BITS-1:0] front_right_mm,
  input  logic                            front_right_ok,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [7:0]               left_cmd,
  output logic signed [7:0]               right_cmd,
  output logic [1:0]                      status,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [11:0]                     cfg_data
);
  import fwas_pkg::*;
  `include "assert_macros.svh"

  cfg_t cfg;
  cmd_t cmd;

  logic                  in_full;
  logic                  in_start;
  logic [31:0]           in_time;
  logic [RANGE_BITS-1:0] in_lmm, in_rmm;
  logic                  in_lok, in_rok;
  logic                  move;

  logic [31:0]       start_time, start_time_next;
  logic [31:0]       stable_since, stable_since_next;
  logic              stable_active, stable_active_next;
  logic              run_active, run_active_next;
  status_t           final_status, final_status_next;
  logic signed [7:0] left_next, right_next;
  status_t           status_next;

  assign move     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_mm     <= 8'd80;
      cfg.max_pwm       <= 7'd60;
      cfg.min_pwm       <= 7'd30;
      cfg.dist_tol_mm   <= 8'd4;
      cfg.square_tol_mm <= 8'd6;
      cfg.dist_gain     <= 12'd512;
      cfg.square_gain   <= 12'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET:      cfg.target_mm     <= cfg_data[7:0];
        CFG_MAX_PWM:     cfg.max_pwm       <= cfg_data[6:0];
        CFG_MIN_PWM:     cfg.min_pwm       <= cfg_data[6:0];
        CFG_DIST_TOL:    cfg.dist_tol_mm   <= cfg_data[7:0];
        CFG_SQUARE_TOL:  cfg.square_tol_mm <= cfg_data[7:0];
        CFG_DIST_GAIN:   cfg.dist_gain     <= cfg_data;
        CFG_SQUARE_GAIN: cfg.square_gain   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_start <= start_req;
      in_time  <= time_ms;
      in_lmm   <= front_left_mm;
      in_lok   <= front_left_ok;
      in_rmm   <= front_right_mm;
      in_rok   <= front_right_ok;
    end
  end

  fwas_cmd u_cmd (
    .left_mm    (in_lmm),
    .left_flag  (in_lok),
    .right_mm   (in_rmm),
    .right_flag (in_rok),
    .cfg        (cfg),
    .res        (cmd)
  );

  always_comb begin
    start_time_next    = start_time;
    stable_since_next  = stable_since;
    stable_active_next = stable_active;
    run_active_next    = run_active;
    final_status_next  = final_status;
    left_next          = '0;
    right_next         = '0;
    status_next        = final_status;
    if (in_start) begin
      start_time_next    = in_time;
      run_active_next    = 1'b1;
      stable_active_next = 1'b0;
      final_status_next  = ST_RUNNING;
    end
    if (!run_active_next) begin
      status_next = final_status_next;
    end else if ((in_time - start_time_next) >= TIMEOUT_MS) begin
      run_active_next    = 1'b0;
      stable_active_next = 1'b0;
      final_status_next  = ST_TIMEOUT;
      status_next        = ST_TIMEOUT;
    end else if (!cmd.lv && !cmd.rv) begin
      run_active_next    = 1'b0;
      stable_active_next = 1'b0;
      final_status_next  = ST_NO_READING;
      status_next        = ST_NO_READING;
    end else if (cmd.dist_ok && cmd.square_ok) begin
      if (!stable_active_next) begin
        stable_active_next = 1'b1;
        stable_since_next  = in_time;
      end
      if ((in_time - stable_since_next) >= STABLE_MS) begin
        run_active_next    = 1'b0;
        stable_active_next = 1'b0;
        final_status_next  = ST_ALIGNED;
        status_next        = ST_ALIGNED;
      end else begin
        status_next = ST_RUNNING;
      end
    end else begin
      stable_active_next = 1'b0;
      left_next          = cmd.left;
      right_next         = cmd.right;
      status_next        = ST_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time    <= '0;
      stable_since  <= '0;
      stable_active <= 1'b0;
      run_active    <= 1'b0;
      final_status  <= ST_RUNNING;
    end else if (move) begin
      start_time    <= start_time_next;
      stable_since  <= stable_since_next;
      stable_active <= stable_active_next;
      run_active    <= run_active_next;
      final_status  <= final_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      left_cmd  <= left_next;
      right_cmd <= right_next;
      status    <= status_next;
    end
  end

  `ASSERT_CLK(a_final_ends_run, clk, rst,
    (move && status_next != ST_RUNNING) |=> !run_active)
  `ASSERT_CLK(a_final_zero_cmd, clk, rst,
    (out_valid && status != ST_RUNNING) |-> (left_cmd == 0 && right_cmd == 0))
  `ASSERT_CLK(a_cmd_range, clk, rst,
    out_valid |-> (left_cmd <= 8'sd100 && left_cmd >= -8'sd100 &&
                   right_cmd <= 8'sd100 && right_cmd >= -8'sd100))
  `ASSERT_ALWAYS(a_stable_in_run, clk, stable_active |-> run_active)
  `ASSERT_CLK(a_hold_request, clk, rst,
    (in_full && !move) |=> (in_full && $stable(in_time) && $stable(in_start)))

endmodule
`default_nettype wire
